@@ design/crt_pkg.sv @@
`default_nettype none
package crt_pkg;

  localparam int CHAPTER_SLOTS = 4;
  localparam int LOCAL_SLOTS   = 12;
  localparam int RECORD_COUNT  = 16;
  localparam int SLOT_W        = 4;
  localparam int CNT_W         = 5;
  localparam int TICK_W        = 31;

  localparam logic [TICK_W-1:0] HISTORY_STRIDE = 31'h07F0000;

  localparam int FLAG_VALID   = 0;
  localparam int FLAG_CHAPTER = 1;
  localparam int FLAG_WINDOW  = 2;
  localparam int FLAG_WORKING = 3;

  localparam logic [2:0] MODE_OPEN   = 3'd0;
  localparam logic [2:0] MODE_COMMIT = 3'd1;
  localparam logic [2:0] MODE_EXACT  = 3'd2;
  localparam logic [2:0] MODE_AFTER  = 3'd3;
  localparam logic [2:0] MODE_BEFORE = 3'd4;
  localparam logic [2:0] MODE_CLEAR  = 3'd5;
  localparam logic [2:0] MODE_QUERY  = 3'd6;
  localparam logic [2:0] MODE_REINIT = 3'd7;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_MISS   = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

  typedef struct packed {
    logic [2:0]        mode;
    logic [TICK_W-1:0] tick;
    logic              chapter_select;
    logic [30:0]       film_offset;
    logic [30:0]       update_count;
    logic [SLOT_W-1:0] slot_index;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [TICK_W-1:0]  slot_tick;
    logic signed [31:0] slot_offset;
    logic signed [31:0] slot_update;
    logic [30:0]        history_offset;
    logic [CNT_W-1:0]   chapter_total;
    logic [CNT_W-1:0]   local_total;
  } out_t;

  typedef struct packed {
    logic [3:0]        flags;
    logic [TICK_W-1:0] tick;
    logic [31:0]       offset;
    logic [31:0]       update;
  } record_t;

  function automatic record_t blank_record();
    record_t r;
    r.flags  = 4'd0;
    r.tick   = '0;
    r.offset = '1;
    r.update = '1;
    return r;
  endfunction

  function automatic logic [30:0] history_of(logic [SLOT_W-1:0] s);
    logic [34:0] p;
    p = 35'(s) * 35'(HISTORY_STRIDE);
    return p[30:0];
  endfunction

endpackage
`default_nettype wire

@@ design/checkpoint_record_table.sv @@
`default_nettype none
// Checkpoint record table: sixteen records held in a ring of cells.
// Command channel: present a word on cmd_i with start high; it is taken at
// the rising edge where start is high and busy is low. busy then stays high
// until the result is issued.
// Result channel: result_o is valid for exactly one cycle while done_o is
// high; it must be taken in that cycle, since the receiver cannot stall.
// Sequence: the ring rotates once to scan every record, a decide state
// settles the plan, and a second rotation writes the changes and counts
// the records. busy falls in the same cycle that done_o rises, so a new
// command can be taken while the result is shown. Every mode takes the
// same time, set by the two ring rotations.
// Reset: all records become invalid with tick 0 and offset and update all
// ones; no result is pending and busy is low.
module checkpoint_record_table
  import crt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  cmd_i,
  output logic      done_o,
  output out_t      result_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_APPLY} state_e;

  state_e            state_q;
  logic [SLOT_W-1:0] cnt_q;
  in_t               cmd_q;
  logic [CNT_W-1:0]  ch_cnt_q, lo_cnt_q;
  logic              work_found_q, free_found_q, ev_found_q, hit_found_q, dup_q;
  logic [SLOT_W-1:0] work_idx_q, free_idx_q, ev_idx_q, hit_idx_q, tgt_idx_q;
  logic [TICK_W-1:0] ev_tick_q;
  record_t           hit_rec_q;
  logic              op_ok_q, evict_q, done_q;
  out_t              res_q;

  record_t chain [RECORD_COUNT];
  record_t head, tail_in, mod_rec;
  logic    shift;

  for (genvar k = 0; k < RECORD_COUNT; k++) begin : g_cell
    record_t feed;
    if (k == RECORD_COUNT - 1) begin : g_tail
      assign feed = tail_in;
    end else begin : g_mid
      assign feed = chain[k+1];
    end
    crt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .rec_i   (feed),
      .rec_o   (chain[k])
    );
  end

  assign head  = chain[0];
  assign shift = (state_q == ST_SCAN) || (state_q == ST_APPLY);

  logic hv, hch, hwin, hwk, cand, better, mv_ch, mv_lo;
  logic open_ok, open_evict;
  logic [SLOT_W-1:0] open_tgt;
  out_t plan;

  always_comb begin
    hv   = head.flags[FLAG_VALID];
    hch  = head.flags[FLAG_CHAPTER];
    hwin = head.flags[FLAG_WINDOW];
    hwk  = head.flags[FLAG_WORKING];

    case (cmd_q.mode)
      MODE_EXACT:  cand = hv && (head.tick == cmd_q.tick);
      MODE_AFTER:  cand = hv && (head.tick > cmd_q.tick);
      MODE_BEFORE: cand = hv && (head.tick <= cmd_q.tick) && (!cmd_q.chapter_select || hch);
      MODE_QUERY:  cand = hv && (cnt_q == cmd_q.slot_index);
      default:     cand = 1'b0;
    endcase

    case (cmd_q.mode)
      MODE_AFTER:  better = !hit_found_q || (head.tick < hit_rec_q.tick);
      MODE_BEFORE: better = !hit_found_q || (head.tick > hit_rec_q.tick);
      default:     better = !hit_found_q;
    endcase

    mod_rec = head;
    case (cmd_q.mode)
      MODE_REINIT: mod_rec = blank_record();
      MODE_CLEAR: begin
        if (hv && hwin) begin
          if (hch) begin
            mod_rec.flags[FLAG_WINDOW] = 1'b0;
          end else begin
            mod_rec = blank_record();
          end
        end
      end
      MODE_OPEN: begin
        if (op_ok_q) begin
          if (evict_q && hv && (head.tick < ev_tick_q)) begin
            mod_rec.flags[FLAG_WINDOW] = 1'b0;
          end
          if (cnt_q == tgt_idx_q) begin
            mod_rec = blank_record();
            mod_rec.flags[FLAG_WORKING] = 1'b1;
            mod_rec.flags[FLAG_WINDOW]  = 1'b1;
            mod_rec.flags[FLAG_CHAPTER] = cmd_q.chapter_select;
          end
        end
      end
      MODE_COMMIT: begin
        if (op_ok_q && (cnt_q == tgt_idx_q)) begin
          mod_rec.tick   = cmd_q.tick;
          mod_rec.offset = {1'b0, cmd_q.film_offset};
          mod_rec.update = {1'b0, cmd_q.update_count};
          mod_rec.flags[FLAG_WORKING] = 1'b0;
          mod_rec.flags[FLAG_VALID]   = 1'b1;
        end
      end
      default: mod_rec = head;
    endcase

    tail_in = (state_q == ST_APPLY) ? mod_rec : head;
    mv_ch   = mod_rec.flags[FLAG_VALID] && mod_rec.flags[FLAG_CHAPTER];
    mv_lo   = mod_rec.flags[FLAG_VALID] && !mod_rec.flags[FLAG_CHAPTER];

    open_ok    = 1'b0;
    open_evict = 1'b0;
    open_tgt   = free_idx_q;
    if (!work_found_q && !(cmd_q.chapter_select && (ch_cnt_q >= CNT_W'(CHAPTER_SLOTS)))) begin
      if ((cmd_q.chapter_select || (lo_cnt_q != CNT_W'(LOCAL_SLOTS))) && free_found_q) begin
        open_ok = 1'b1;
      end else if (!cmd_q.chapter_select && ev_found_q) begin
        open_ok    = 1'b1;
        open_evict = 1'b1;
        open_tgt   = ev_idx_q;
      end
    end

    plan        = '0;
    plan.status = STATUS_OK;
    case (cmd_q.mode)
      MODE_OPEN: begin
        if (open_ok) begin
          plan.slot           = open_tgt;
          plan.slot_offset    = '1;
          plan.slot_update    = '1;
          plan.history_offset = history_of(open_tgt);
        end else begin
          plan.status = STATUS_REJECT;
        end
      end
      MODE_COMMIT: begin
        if (work_found_q) begin
          plan.slot           = work_idx_q;
          plan.slot_tick      = cmd_q.tick;
          plan.slot_offset    = {1'b0, cmd_q.film_offset};
          plan.slot_update    = {1'b0, cmd_q.update_count};
          plan.history_offset = history_of(work_idx_q);
        end else begin
          plan.status = STATUS_REJECT;
        end
      end
      MODE_EXACT, MODE_AFTER, MODE_BEFORE, MODE_QUERY: begin
        if ((cmd_q.mode == MODE_EXACT) && dup_q) begin
          plan.status = STATUS_REJECT;
        end else if (hit_found_q) begin
          plan.slot           = hit_idx_q;
          plan.slot_tick      = hit_rec_q.tick;
          plan.slot_offset    = hit_rec_q.offset;
          plan.slot_update    = hit_rec_q.update;
          plan.history_offset = history_of(hit_idx_q);
        end else begin
          plan.status = STATUS_MISS;
        end
        if (cmd_q.mode == MODE_QUERY) begin
          plan.slot = cmd_q.slot_index;
        end
      end
      default: plan.status = STATUS_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      cmd_q        <= '0;
      ch_cnt_q     <= '0;
      lo_cnt_q     <= '0;
      work_found_q <= 1'b0;
      free_found_q <= 1'b0;
      ev_found_q   <= 1'b0;
      hit_found_q  <= 1'b0;
      dup_q        <= 1'b0;
      work_idx_q   <= '0;
      free_idx_q   <= '0;
      ev_idx_q     <= '0;
      hit_idx_q    <= '0;
      tgt_idx_q    <= '0;
      ev_tick_q    <= '0;
      hit_rec_q    <= '0;
      op_ok_q      <= 1'b0;
      evict_q      <= 1'b0;
      done_q       <= 1'b0;
      res_q        <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            cmd_q        <= cmd_i;
            cnt_q        <= '0;
            ch_cnt_q     <= '0;
            lo_cnt_q     <= '0;
            work_found_q <= 1'b0;
            free_found_q <= 1'b0;
            ev_found_q   <= 1'b0;
            hit_found_q  <= 1'b0;
            dup_q        <= 1'b0;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hv && hch) ch_cnt_q <= ch_cnt_q + 1'b1;
          if (hv && !hch) lo_cnt_q <= lo_cnt_q + 1'b1;
          if (hwk && !work_found_q) begin
            work_found_q <= 1'b1;
            work_idx_q   <= cnt_q;
          end
          if (!hv && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= cnt_q;
          end
          if (hv && !hch && (!ev_found_q || (head.tick < ev_tick_q))) begin
            ev_found_q <= 1'b1;
            ev_idx_q   <= cnt_q;
            ev_tick_q  <= head.tick;
          end
          if (cand && hit_found_q) dup_q <= 1'b1;
          if (cand && better) begin
            hit_found_q <= 1'b1;
            hit_idx_q   <= cnt_q;
            hit_rec_q   <= head;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == SLOT_W'(RECORD_COUNT - 1)) state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          res_q     <= plan;
          op_ok_q   <= (cmd_q.mode == MODE_OPEN) ? open_ok : work_found_q;
          evict_q   <= open_evict;
          tgt_idx_q <= (cmd_q.mode == MODE_OPEN) ? open_tgt : work_idx_q;
          ch_cnt_q  <= '0;
          lo_cnt_q  <= '0;
          cnt_q     <= '0;
          state_q   <= ST_APPLY;
        end
        ST_APPLY: begin
          ch_cnt_q <= ch_cnt_q + CNT_W'(mv_ch);
          lo_cnt_q <= lo_cnt_q + CNT_W'(mv_lo);
          cnt_q    <= cnt_q + 1'b1;
          if (cnt_q == SLOT_W'(RECORD_COUNT - 1)) begin
            res_q.chapter_total <= ch_cnt_q + CNT_W'(mv_ch);
            res_q.local_total   <= lo_cnt_q + CNT_W'(mv_lo);
            done_q              <= 1'b1;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

@@ design/crt_cell.sv @@
`default_nettype none
module crt_cell
  import crt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    shift_i,
  input  wire record_t rec_i,
  output record_t      rec_o
);

  record_t rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= blank_record();
    end else if (shift_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule
`default_nettype wire

@@ design/crt_checker.sv @@
`default_nettype none
module crt_checker
  import crt_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o,
  input wire out_t result_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result issued while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result word repeated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((result_o.status != 2'd3)
               && (result_o.chapter_total <= 5'd16)
               && (result_o.local_total <= 5'd16)))
    else $error("result word out of range");

endmodule

bind checkpoint_record_table crt_checker u_crt_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import crt_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t cmd_i = '0;
  logic done_o;
  out_t result_o;

  checkpoint_record_table i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .cmd_i(cmd_i),
    .done_o(done_o),
    .result_o(result_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  in_t pending_words[$];
  out_t expected_results[$];
  record_t table_model[RECORD_COUNT];
  int gap_pct = 24;
  int errors = 0;
  int cycles = 0;
  bit stim_done = 1'b0;

  function automatic logic [CNT_W-1:0] count_valid(bit chapters);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < RECORD_COUNT; i++)
      if (table_model[i].flags[FLAG_VALID] && (table_model[i].flags[FLAG_CHAPTER] == chapters))
        n++;
    return n;
  endfunction

  function automatic int find_working();
    for (int i = 0; i < RECORD_COUNT; i++)
      if (table_model[i].flags[FLAG_WORKING]) return i;
    return -1;
  endfunction

  function automatic record_t cleared();
    record_t r;
    r.flags = '0;
    r.tick = '0;
    r.offset = '1;
    r.update = '1;
    return r;
  endfunction

  function automatic int open_slot(bit chapter);
    int s;
    s = -1;
    if (find_working() >= 0) return -1;
    if (chapter && count_valid(1'b1) >= CHAPTER_SLOTS) return -1;
    if (chapter || count_valid(1'b0) != LOCAL_SLOTS) begin
      for (int i = 0; i < RECORD_COUNT; i++)
        if (s < 0 && !table_model[i].flags[FLAG_VALID]) s = i;
    end
    if (s < 0) begin
      if (chapter) return -1;
      for (int i = 0; i < RECORD_COUNT; i++)
        if (table_model[i].flags[FLAG_VALID] && !table_model[i].flags[FLAG_CHAPTER])
          if (s < 0 || table_model[i].tick < table_model[s].tick) s = i;
      if (s < 0) return -1;
      for (int i = 0; i < RECORD_COUNT; i++)
        if (table_model[i].flags[FLAG_VALID] && table_model[i].tick < table_model[s].tick)
          table_model[i].flags[FLAG_WINDOW] = 1'b0;
    end
    table_model[s] = cleared();
    table_model[s].flags[FLAG_WORKING] = 1'b1;
    table_model[s].flags[FLAG_WINDOW] = 1'b1;
    table_model[s].flags[FLAG_CHAPTER] = chapter;
    return s;
  endfunction

  function automatic out_t table_step(in_t w);
    out_t r;
    int hit;
    logic [1:0] st;
    hit = -1;
    st = STATUS_OK;
    r = '0;
    case (w.mode)
      MODE_OPEN: begin
        hit = open_slot(w.chapter_select);
        if (hit < 0) st = STATUS_REJECT;
      end
      MODE_COMMIT: begin
        hit = find_working();
        if (hit < 0) st = STATUS_REJECT;
        else begin
          table_model[hit].tick = w.tick;
          table_model[hit].offset = {1'b0, w.film_offset};
          table_model[hit].update = {1'b0, w.update_count};
          table_model[hit].flags[FLAG_WORKING] = 1'b0;
          table_model[hit].flags[FLAG_VALID] = 1'b1;
        end
      end
      MODE_EXACT: begin
        for (int i = 0; i < RECORD_COUNT; i++)
          if (st == STATUS_OK && table_model[i].flags[FLAG_VALID]
              && table_model[i].tick == w.tick) begin
            if (hit >= 0) st = STATUS_REJECT;
            else hit = i;
          end
        if (st == STATUS_REJECT) hit = -1;
        else if (hit < 0) st = STATUS_MISS;
      end
      MODE_AFTER: begin
        for (int i = 0; i < RECORD_COUNT; i++)
          if (table_model[i].flags[FLAG_VALID] && table_model[i].tick > w.tick)
            if (hit < 0 || table_model[i].tick < table_model[hit].tick) hit = i;
        if (hit < 0) st = STATUS_MISS;
      end
      MODE_BEFORE: begin
        for (int i = 0; i < RECORD_COUNT; i++)
          if (table_model[i].flags[FLAG_VALID] && table_model[i].tick <= w.tick
              && (!w.chapter_select || table_model[i].flags[FLAG_CHAPTER]))
            if (hit < 0 || table_model[i].tick > table_model[hit].tick) hit = i;
        if (hit < 0) st = STATUS_MISS;
      end
      MODE_CLEAR: begin
        for (int i = 0; i < RECORD_COUNT; i++)
          if (table_model[i].flags[FLAG_VALID] && table_model[i].flags[FLAG_WINDOW]) begin
            if (table_model[i].flags[FLAG_CHAPTER]) table_model[i].flags[FLAG_WINDOW] = 1'b0;
            else table_model[i] = cleared();
          end
      end
      MODE_QUERY: begin
        if (table_model[w.slot_index].flags[FLAG_VALID]) hit = int'(w.slot_index);
        else st = STATUS_MISS;
      end
      default: begin
        for (int i = 0; i < RECORD_COUNT; i++) table_model[i] = cleared();
      end
    endcase
    if (hit >= 0) begin
      r.slot = hit[SLOT_W-1:0];
      r.slot_tick = table_model[hit].tick;
      r.slot_offset = table_model[hit].offset;
      r.slot_update = table_model[hit].update;
      r.history_offset = 31'(hit * 32'h007F0000);
    end
    if (w.mode == MODE_QUERY) r.slot = w.slot_index;
    r.status = st;
    r.chapter_total = count_valid(1'b1);
    r.local_total = count_valid(1'b0);
    return r;
  endfunction

  // tick pool keeps duplicates and near-miss searches common
  function automatic logic [30:0] pick_tick();
    case ($urandom_range(0, 4))
      0: return 31'($urandom_range(0, 40));
      1: return 31'h7FFFFFFF - 31'($urandom_range(0, 3));
      2: return 31'($urandom_range(0, 8) * 100);
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic in_t make_word(logic [2:0] m);
    in_t w;
    w.mode = m;
    w.tick = pick_tick();
    w.chapter_select = ($urandom_range(0, 3) == 0);
    w.film_offset = 31'($urandom());
    w.update_count = 31'($urandom());
    w.slot_index = 4'($urandom_range(0, 15));
    return w;
  endfunction

  initial begin
    in_t w;
    int r;
    w = make_word(MODE_QUERY);
    w.slot_index = 4'd0;
    pending_words.push_back(w);
    pending_words.push_back(make_word(MODE_COMMIT));
    pending_words.push_back(make_word(MODE_EXACT));
    pending_words.push_back(make_word(MODE_AFTER));
    pending_words.push_back(make_word(MODE_BEFORE));
    for (int i = 0; i < 6; i++) begin
      w = make_word(MODE_OPEN);
      w.chapter_select = (i < 5);
      pending_words.push_back(w);
      pending_words.push_back(make_word(MODE_OPEN));
      w = make_word(MODE_COMMIT);
      w.tick = (i == 0) ? 31'd0 : (i == 1) ? 31'h7FFFFFFF : 31'd500;
      w.film_offset = (i == 1) ? 31'h7FFFFFFF : 31'd0;
      w.update_count = (i == 1) ? 31'h7FFFFFFF : 31'd0;
      pending_words.push_back(w);
    end
    w = make_word(MODE_EXACT);
    w.tick = 31'd500;
    pending_words.push_back(w);
    w = make_word(MODE_QUERY);
    w.slot_index = 4'd15;
    pending_words.push_back(w);
    pending_words.push_back(make_word(MODE_CLEAR));
    pending_words.push_back(make_word(MODE_REINIT));
    for (int n = 0; n < 1150; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30) w = make_word(MODE_OPEN);
      else if (r < 60) w = make_word(MODE_COMMIT);
      else if (r < 90) w = make_word(3'($urandom_range(MODE_EXACT, MODE_BEFORE)));
      else if (r < 94) w = make_word(MODE_QUERY);
      else if (r < 98) w = make_word(MODE_CLEAR);
      else w = make_word(MODE_REINIT);
      pending_words.push_back(w);
    end
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_results.push_back(table_step(cmd_i));
        void'(pending_words.pop_front());
      end
      if ((!start || !busy) && pending_words.size() > 0
          && $urandom_range(0, 99) >= gap_pct) begin
        start <= 1'b1;
        cmd_i <= pending_words[0];
      end else if (start && !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t e;
    cycles <= cycles + 1;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (result_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result_o.status); errors++;
        end
        if (result_o.slot !== e.slot) begin
          $error("slot exp %0d got %0d", e.slot, result_o.slot); errors++;
        end
        if (result_o.slot_tick !== e.slot_tick) begin
          $error("slot_tick exp %0h got %0h", e.slot_tick, result_o.slot_tick); errors++;
        end
        if (result_o.slot_offset !== e.slot_offset) begin
          $error("slot_offset exp %0h got %0h", e.slot_offset, result_o.slot_offset);
          errors++;
        end
        if (result_o.slot_update !== e.slot_update) begin
          $error("slot_update exp %0h got %0h", e.slot_update, result_o.slot_update);
          errors++;
        end
        if (result_o.history_offset !== e.history_offset) begin
          $error("history_offset exp %0h got %0h", e.history_offset, result_o.history_offset);
          errors++;
        end
        if (result_o.chapter_total !== e.chapter_total) begin
          $error("chapter_total exp %0d got %0d", e.chapter_total, result_o.chapter_total);
          errors++;
        end
        if (result_o.local_total !== e.local_total) begin
          $error("local_total exp %0d got %0d", e.local_total, result_o.local_total);
          errors++;
        end
      end
    end
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < RECORD_COUNT; i++) table_model[i] = cleared();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_words.size() < 780);
    gap_pct = 49;
    wait (pending_words.size() < 400);
    gap_pct = 0;
    wait (pending_words.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/crt_pkg.sv
design/crt_cell.sv
design/checkpoint_record_table.sv
design/crt_checker.sv
verif/tb_top.sv
